// File: rtl/core/iqsq_pkg.sv
// Shared types and constants for the IQ sample quantizer.
// Used by the lane, pack and top-level modules under rtl/core; depends on nothing.
package iqsq_pkg;

	// Sample format codes held in the format register
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_I8  = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_I16 = 3'd3;
	localparam logic [2:0] FMT_F32 = 3'd4;

	// Register stages inside one lane
	localparam int NUM_STG = 7;

	// Fixed-point magnitude: 18 integer bits, 26 fraction bits, one jam bit
	localparam int FX_W   = 45;
	localparam int FRAC_W = 27;

	// Unsigned offsets 127.5 and 32767.5 on the fixed-point grid
	localparam logic [FX_W-1:0] KFX_U8  = 45'd255 << 26;
	localparam logic [FX_W-1:0] KFX_U16 = 45'd65535 << 26;

	typedef struct packed {
		logic [NUM_STG-1:0] en;
		logic [2:0]         fmt;
	} iqsq_lane_ctl_t;

endpackage

// File: rtl/core/iqsq_lane.sv
// One quantizer lane: single-precision word to saturated 8/16-bit code.
// Seven register stages; depends on iqsq_pkg.
module iqsq_lane (
	input  logic                    clk,
	input  iqsq_pkg::iqsq_lane_ctl_t ctl,
	input  logic [31:0]             word,
	output logic [15:0]             code,
	output logic [31:0]             raw
);
	import iqsq_pkg::*;

	// ---------------- stage 1: unpack, scale multiply
	logic        is_nan, is_tiny, is_sat, is_zero;
	logic [23:0] mant;
	logic [15:0] kmul;
	logic [39:0] prod_c;

	logic        sgn_s1, sat_s1;
	logic [7:0]  exp_s1;
	logic [39:0] prod_s1;
	logic [31:0] raw_s1;

	assign is_nan  = (word[30:23] == 8'hFF) && (word[22:0] != 23'd0);
	assign is_tiny = word[30:23] < 8'd87;
	assign is_sat  = (word[30:23] >= 8'd128) && !is_nan;
	assign is_zero = is_nan || is_tiny;
	assign mant    = is_zero ? 24'd0 : {1'b1, word[22:0]};

	always_comb begin
		case (ctl.fmt)
			FMT_U8:  kmul = 16'd255;
			FMT_I8:  kmul = 16'd127;
			FMT_U16: kmul = 16'd65535;
			default: kmul = 16'd32767;
		endcase
	end

	assign prod_c = mant * kmul;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			sgn_s1  <= word[31] && !is_zero;
			sat_s1  <= is_sat;
			exp_s1  <= word[30:23];
			prod_s1 <= prod_c;
			raw_s1  <= word;
		end
	end

	// ---------------- stage 2: round product to 24 significant bits
	logic [4:0]        base_sh, sh;
	logic              ks;
	logic [5:0]        top_idx, gidx;
	logic [39:0]       shifted, smask;
	logic              guard_p, sticky_p, up_p;
	logic [24:0]       rnd_c;
	logic signed [9:0] xexp;

	logic              sgn_s2, sat_s2;
	logic [24:0]       mant_s2;
	logic signed [7:0] amt_s2;
	logic [31:0]       raw_s2;

	always_comb begin
		case (ctl.fmt)
			FMT_U8:  base_sh = 5'd7;
			FMT_I8:  base_sh = 5'd6;
			FMT_U16: base_sh = 5'd15;
			default: base_sh = 5'd14;
		endcase
	end

	assign ks       = (ctl.fmt == FMT_U8) || (ctl.fmt == FMT_U16);
	assign top_idx  = {1'b0, base_sh} + 6'd24;
	assign sh       = base_sh + {4'd0, prod_s1[top_idx]};
	assign shifted  = prod_s1 >> sh;
	assign gidx     = {1'b0, sh} - 6'd1;
	assign guard_p  = prod_s1[gidx];
	assign smask    = ~({40{1'b1}} << gidx);
	assign sticky_p = |(prod_s1 & smask);
	assign up_p     = guard_p && (sticky_p || shifted[0]);
	assign rnd_c    = {1'b0, shifted[23:0]} + {24'd0, up_p};
	assign xexp     = $signed({2'b00, exp_s1}) - 10'sd150 - $signed({9'd0, ks})
		+ $signed({5'd0, sh});

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			sgn_s2  <= sgn_s1;
			sat_s2  <= sat_s1;
			mant_s2 <= rnd_c;
			amt_s2  <= 8'(xexp + 10'sd26);
			raw_s2  <= raw_s1;
		end
	end

	// ---------------- stage 3: align onto the fixed-point grid, jam lost bits
	logic [43:0] r_ext, grid_c;
	logic [7:0]  neg_amt;
	logic [5:0]  ramt;
	logic        jam;

	logic            sgn_s3, sat_s3;
	logic [FX_W-1:0] fx_s3;
	logic [31:0]     raw_s3;

	assign r_ext   = {19'd0, mant_s2};
	assign neg_amt = -amt_s2;
	assign ramt    = neg_amt[5:0];

	always_comb begin
		if (!amt_s2[7]) begin
			grid_c = r_ext << amt_s2[5:0];
			jam    = 1'b0;
		end else begin
			grid_c = r_ext >> ramt;
			jam    = |(mant_s2 & ~({25{1'b1}} << ramt));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			sgn_s3 <= sgn_s2;
			sat_s3 <= sat_s2;
			fx_s3  <= {grid_c, jam};
			raw_s3 <= raw_s2;
		end
	end

	// ---------------- stage 4: add the unsigned offset, split sign and magnitude
	logic [FX_W-1:0] kfx, mag_c;
	logic [FX_W:0]   dif;
	logic            neg_c;

	logic            sgn_s4, sat_s4, neg_s4;
	logic [FX_W-1:0] mag_s4;
	logic [31:0]     raw_s4;

	always_comb begin
		case (ctl.fmt)
			FMT_U8:  kfx = KFX_U8;
			FMT_U16: kfx = KFX_U16;
			default: kfx = '0;
		endcase
		dif = {1'b0, kfx} - {1'b0, fx_s3};
		if (!sgn_s3) begin
			mag_c = kfx + fx_s3;
			neg_c = 1'b0;
		end else if (dif[FX_W]) begin
			mag_c = fx_s3 - kfx;
			neg_c = 1'b1;
		end else begin
			mag_c = dif[FX_W-1:0];
			neg_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			sgn_s4 <= sgn_s3;
			sat_s4 <= sat_s3;
			neg_s4 <= neg_c;
			mag_s4 <= mag_c;
			raw_s4 <= raw_s3;
		end
	end

	// ---------------- stage 5: find the leading one
	logic [5:0] lead;
	logic       small_c;

	logic            sgn_s5, sat_s5, neg_s5, small_s5;
	logic [4:0]      lsb_s5;
	logic [FX_W-1:0] mag_s5;
	logic [31:0]     raw_s5;

	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < FX_W; i++) begin
			if (mag_s4[i]) begin
				lead = 6'(i);
			end
		end
	end

	// below a quarter the result is zero in every format
	assign small_c = (mag_s4[FX_W-1:25] == '0);

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			sgn_s5   <= sgn_s4;
			sat_s5   <= sat_s4;
			neg_s5   <= neg_s4;
			small_s5 <= small_c;
			lsb_s5   <= 5'(lead - 6'd23);
			mag_s5   <= mag_s4;
			raw_s5   <= raw_s4;
		end
	end

	// ---------------- stage 6: round the sum to single precision (unsigned formats only)
	logic [4:0]      rm1;
	logic [FX_W-1:0] lowm, gm, rnd_mag;
	logic            guard_s, sticky_s, up_s, unsig;

	logic            sgn_s6, sat_s6, neg_s6;
	logic [FX_W-1:0] mag_s6;
	logic [31:0]     raw_s6;

	assign unsig    = (ctl.fmt == FMT_U8) || (ctl.fmt == FMT_U16);
	assign rm1      = lsb_s5 - 5'd1;
	assign lowm     = ~({FX_W{1'b1}} << lsb_s5);
	assign gm       = ~({FX_W{1'b1}} << rm1);
	assign guard_s  = mag_s5[rm1];
	assign sticky_s = |(mag_s5 & gm);
	assign up_s     = guard_s && (sticky_s || mag_s5[lsb_s5]);

	always_comb begin
		if (small_s5) begin
			rnd_mag = '0;
		end else if (!unsig) begin
			rnd_mag = mag_s5;
		end else begin
			rnd_mag = (mag_s5 & ~lowm) + (up_s ? (45'd1 << lsb_s5) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			sgn_s6 <= sgn_s5;
			sat_s6 <= sat_s5;
			neg_s6 <= neg_s5;
			mag_s6 <= rnd_mag;
			raw_s6 <= raw_s5;
		end
	end

	// ---------------- stage 7: round half away from zero, saturate
	logic [15:0] hi;
	logic [18:0] nint, lim, clip;
	logic        unsig7;
	logic [15:0] code_c;

	logic [15:0] code_s7;
	logic [31:0] raw_s7;

	always_comb begin
		case (ctl.fmt)
			FMT_U8:  hi = 16'd255;
			FMT_I8:  hi = 16'd127;
			FMT_U16: hi = 16'd65535;
			default: hi = 16'd32767;
		endcase
	end

	assign unsig7 = (ctl.fmt == FMT_U8) || (ctl.fmt == FMT_U16);
	assign nint   = {1'b0, mag_s6[FX_W-1:FRAC_W]} + {18'd0, mag_s6[FRAC_W-1]};
	assign lim    = {3'd0, hi} + {18'd0, neg_s6 && !unsig7};
	assign clip   = (nint > lim) ? lim : nint;

	always_comb begin
		if (sat_s6) begin
			if (!sgn_s6) begin
				code_c = hi;
			end else if (unsig7) begin
				code_c = 16'd0;
			end else begin
				code_c = ~hi;
			end
		end else if (!neg_s6) begin
			code_c = clip[15:0];
		end else if (unsig7) begin
			code_c = 16'd0;
		end else begin
			code_c = 16'(-clip);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			code_s7 <= code_c;
			raw_s7  <= raw_s6;
		end
	end

	assign code = code_s7;
	assign raw  = raw_s7;

endmodule

// File: rtl/core/iqsq_pack.sv
// Merge stage: packs the I and Q lane results into the output word register.
// Depends on iqsq_pkg.
module iqsq_pack (
	input  logic        clk,
	input  logic        load,
	input  logic [2:0]  fmt,
	input  logic [15:0] code_i,
	input  logic [15:0] code_q,
	input  logic [31:0] raw_i,
	input  logic [31:0] raw_q,
	input  logic        last_i,
	output logic [63:0] packed_bytes,
	output logic [3:0]  byte_count,
	output logic        last_out
);
	import iqsq_pkg::*;

	logic [63:0] pk_c;
	logic [3:0]  bc_c;
	logic [63:0] pk_q;
	logic [3:0]  bc_q;
	logic        last_q;

	always_comb begin
		case (fmt)
			FMT_U8, FMT_I8: begin
				pk_c = {48'd0, code_q[7:0], code_i[7:0]};
				bc_c = 4'd2;
			end
			FMT_U16, FMT_I16: begin
				pk_c = {32'd0, code_q, code_i};
				bc_c = 4'd4;
			end
			FMT_F32: begin
				pk_c = {raw_q, raw_i};
				bc_c = 4'd8;
			end
			default: begin
				pk_c = {raw_q, raw_i};
				bc_c = 4'd8;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pk_q   <= pk_c;
			bc_q   <= bc_c;
			last_q <= last_i;
		end
	end

	assign packed_bytes = pk_q;
	assign byte_count   = bc_q;
	assign last_out     = last_q;

endmodule

// File: rtl/core/iq_sample_quantizer_top.sv
// Top level of the IQ sample quantizer: format register, I and Q lanes, pack stage.
// Depends on iqsq_pkg, iqsq_lane and iqsq_pack.
//
// Takes one complex sample per clock while in_stall is low, as two single-precision
// words, and returns it in the programmed sample format (uint8, int8, uint16, int16
// or float32 passthrough), I in the low bytes, little-endian, unused upper bytes
// zero. Scaling, offset and rounding match single-precision arithmetic exactly,
// with round half away from zero and saturation; NaN reads as zero. Two
// identical lanes carry I and Q side by side through seven register stages
// (multiply, product rounding, alignment, offset add, leading-one search, sum
// rounding, final rounding and clamp), and the pack stage adds an output
// register, so one word is accepted every cycle while out_stall does not back up
// the pipe. Each stage advances whenever the stage after it is free, so bubbles
// collapse and a new word is still taken under out_stall while any stage is
// empty. Write sample_format only while no word is in flight.
module iq_sample_quantizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] real_bits,
	input  logic [31:0] imag_bits,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] packed_bytes,
	output logic [3:0]  byte_count,
	output logic        last_out
);
	import iqsq_pkg::*;

	logic [2:0]         fmt_q;
	logic [NUM_STG-1:0] stg_vld_q;
	logic [NUM_STG-1:0] last_q;
	logic               out_vld_q;
	logic [NUM_STG:0]   rdy;
	iqsq_lane_ctl_t     lane_ctl;
	logic [15:0]        code_i, code_q;
	logic [31:0]        raw_i, raw_q;

	// Format register; the user must write it only while the pipe is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_U8;
		end else if (cfg_we) begin
			fmt_q <= cfg_data;
		end
	end

	// Ready ripples back from the output register: a stage may load when it
	// is empty or when the stage after it loads in the same cycle.
	always_comb begin
		rdy[NUM_STG] = !out_vld_q || !out_stall;
		for (int i = NUM_STG - 1; i >= 0; i--) begin
			rdy[i] = !stg_vld_q[i] || rdy[i+1];
		end
	end

	assign in_stall = !rdy[0];

	// Advance the valid and last flags alongside the lane data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				stg_vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STG; i++) begin
				if (rdy[i]) begin
					stg_vld_q[i] <= stg_vld_q[i-1];
				end
			end
			if (rdy[NUM_STG]) begin
				out_vld_q <= stg_vld_q[NUM_STG-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			last_q[0] <= last_in;
		end
		for (int i = 1; i < NUM_STG; i++) begin
			if (rdy[i]) begin
				last_q[i] <= last_q[i-1];
			end
		end
	end

	assign lane_ctl.en  = rdy[NUM_STG-1:0];
	assign lane_ctl.fmt = fmt_q;

	iqsq_lane u_lane_i (
		.clk  (clk),
		.ctl  (lane_ctl),
		.word (real_bits),
		.code (code_i),
		.raw  (raw_i)
	);

	iqsq_lane u_lane_q (
		.clk  (clk),
		.ctl  (lane_ctl),
		.word (imag_bits),
		.code (code_q),
		.raw  (raw_q)
	);

	// Load the output register only with a real word
	iqsq_pack u_pack (
		.clk          (clk),
		.load         (rdy[NUM_STG] && stg_vld_q[NUM_STG-1]),
		.fmt          (fmt_q),
		.code_i       (code_i),
		.code_q       (code_q),
		.raw_i        (raw_i),
		.raw_q        (raw_q),
		.last_i       (last_q[NUM_STG-1]),
		.packed_bytes (packed_bytes),
		.byte_count   (byte_count),
		.last_out     (last_out)
	);

	assign out_valid = out_vld_q;

endmodule

// File: rtl/core/iqsq_checker.sv
// Port-level checks for the IQ sample quantizer, bound to the top level.
// Depends only on the top level's ports.
module iqsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] packed_bytes,
	input logic [3:0]  byte_count,
	input logic        last_out
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packed_bytes)
			&& $stable(byte_count) && $stable(last_out))
		else $error("stalled output word changed");

	// With the output register empty the whole pipe can advance
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_count == 4'd2) || (byte_count == 4'd4) || (byte_count == 4'd8))
		else $error("illegal byte count");

	a_pad8: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_count == 4'd2) |-> (packed_bytes[63:16] == 48'd0))
		else $error("nonzero bytes above an 8-bit sample pair");

	a_pad16: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_count == 4'd4) |-> (packed_bytes[63:32] == 32'd0))
		else $error("nonzero bytes above a 16-bit sample pair");

endmodule

bind iq_sample_quantizer_top iqsq_checker u_iqsq_checker (.*);
